/* design/tcbdf_pkg.sv */
// Shared types and constants for the text cell buffer with diff flush.
// No dependencies; imported by every module of the block.
package tcbdf_pkg;

  localparam int ROWS        = 16;
  localparam int COLUMNS     = 32;
  localparam int VOICES      = 4;
  localparam int COLOR_COUNT = 16;

  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int IDX_W   = (ADDR_W > VOICE_W) ? ADDR_W : VOICE_W;

  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_SOUND = 1'b1;

  typedef enum logic [1:0] {
    OP_CELL        = 2'd0,
    OP_SOUND       = 2'd1,
    OP_ROW_FLUSH   = 2'd2,
    OP_SOUND_FLUSH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_TAIL,
    ST_SOUND,
    ST_FLUSH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch the item, perform writes
    logic clr_step;   // zero one cell address of every store
    logic row_issue;  // read one cell of the flushed row
    logic snd_step;   // compare one sound channel
    logic flush_hold; // release the held result as the last one
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic end_cells;
    logic end_cols;
    logic end_voices;
    logic row_ok;
  } sts_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] place;
    logic [3:0] line;
    logic [7:0] code;
    logic [7:0] level;
    logic [3:0] back;
    logic [2:0] mask;
  } res_t;

endpackage

/* design/tcbdf_ctrl.sv */
// Sequencing state machine for the text cell buffer.
// Depends on tcbdf_pkg for state, operation, command and status types.
module tcbdf_ctrl import tcbdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] operation_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.end_cells) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          case (op_e'(operation_i))
            OP_ROW_FLUSH: begin
              if (sts_i.row_ok) state_d = ST_ROW;
            end
            OP_SOUND_FLUSH: state_d = ST_SOUND;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ROW: begin
        cmd_o.row_issue = 1'b1;
        if (sts_i.end_cols) state_d = ST_TAIL;
      end
      ST_TAIL: state_d = ST_FLUSH;  // last read word is compared here
      ST_SOUND: begin
        cmd_o.snd_step = 1'b1;
        if (sts_i.end_voices) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd_o.flush_hold = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* design/tcbdf_dp.sv */
// Datapath: cell stores, sound registers, scan counter, result hold and output.
// Depends on tcbdf_pkg; driven by tcbdf_ctrl commands.
module tcbdf_dp import tcbdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [1:0] operation_i,
  input  logic [6:0] column_i,
  input  logic [5:0] row_i,
  input  logic [7:0] glyph_i,
  input  logic [5:0] fore_color_i,
  input  logic [5:0] back_color_i,
  input  logic [1:0] channel_i,
  input  logic [7:0] note_i,
  input  logic [7:0] volume_i,
  output logic       valid_o,
  output res_t       res_o,
  output logic       last_o
);

  // cell stores
  logic [7:0]  pend_glyph_mem [CELLS];
  logic [3:0]  pend_fore_mem  [CELLS];
  logic [3:0]  pend_back_mem  [CELLS];
  logic [15:0] shown_mem      [CELLS];  // {glyph, fore, back}

  logic [7:0]  pg_q;
  logic [3:0]  pf_q, pb_q;
  logic [15:0] sh_q;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [ROW_W-1:0]  row_q;
  logic              rd_vld_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [COL_W-1:0]  rd_col_q;

  logic [7:0] pnote_q [VOICES];
  logic [7:0] pvol_q  [VOICES];
  logic [7:0] snote_q [VOICES];
  logic [7:0] svol_q  [VOICES];

  res_t hold_q;
  logic hold_vld_q;
  logic valid_q, last_q;
  res_t res_q;

  // input decode
  logic              col_ok, row_ok, fore_ok, back_ok, ch_ok;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [VOICE_W-1:0] ch_w, ch_s;
  op_e               op;

  assign op      = op_e'(operation_i);
  assign col_ok  = !column_i[6] && (7'(column_i[5:0]) < 7'(COLUMNS));
  assign row_ok  = !row_i[5] && (7'(row_i[4:0]) < 7'(ROWS));
  assign fore_ok = !fore_color_i[5] && (6'(fore_color_i[4:0]) < 6'(COLOR_COUNT));
  assign back_ok = !back_color_i[5] && (6'(back_color_i[4:0]) < 6'(COLOR_COUNT));
  assign ch_ok   = 5'(channel_i) < 5'(VOICES);
  assign ch_w    = VOICE_W'(channel_i);
  assign ch_s    = idx_q[VOICE_W-1:0];
  assign wr_addr = ADDR_W'(12'(row_i[4:0]) * 12'(COLUMNS) + 12'(column_i[5:0]));
  assign rd_addr = ADDR_W'(12'(row_q) * 12'(COLUMNS) + 12'(idx_q[COL_W-1:0]));

  logic cell_wr, snd_wr;
  assign cell_wr = cmd_i.accept && (op == OP_CELL) && col_ok && row_ok;
  assign snd_wr  = cmd_i.accept && (op == OP_SOUND) && ch_ok;

  // status
  assign sts_o.end_cells  = idx_q == IDX_W'(CELLS - 1);
  assign sts_o.end_cols   = idx_q == IDX_W'(COLUMNS - 1);
  assign sts_o.end_voices = idx_q == IDX_W'(VOICES - 1);
  assign sts_o.row_ok     = row_ok;

  // scan counter
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.accept) begin
      idx_d = '0;
    end else if (cmd_i.clr_step || cmd_i.row_issue || cmd_i.snd_step) begin
      idx_d = (sts_o.end_cells && cmd_i.clr_step) ? '0 : idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      rd_vld_q <= cmd_i.row_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) row_q <= ROW_W'(row_i[4:0]);
    if (cmd_i.row_issue) begin
      rd_addr_q <= rd_addr;
      rd_col_q  <= idx_q[COL_W-1:0];
    end
  end

  // pending stores: one write port each, read port for the scan
  logic [ADDR_W-1:0] pw_addr;
  assign pw_addr = cmd_i.clr_step ? idx_q[ADDR_W-1:0] : wr_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step || cell_wr) pend_glyph_mem[pw_addr] <= cmd_i.clr_step ? 8'd0 : glyph_i;
    if (cmd_i.clr_step || (cell_wr && fore_ok))
      pend_fore_mem[pw_addr] <= cmd_i.clr_step ? 4'd0 : fore_color_i[3:0];
    if (cmd_i.clr_step || (cell_wr && back_ok))
      pend_back_mem[pw_addr] <= cmd_i.clr_step ? 4'd0 : back_color_i[3:0];
    if (cmd_i.row_issue) begin
      pg_q <= pend_glyph_mem[rd_addr];
      pf_q <= pend_fore_mem[rd_addr];
      pb_q <= pend_back_mem[rd_addr];
    end
  end

  // cell compare
  logic [2:0] cell_mask;
  logic       cell_hit;
  assign cell_mask = {pf_q != sh_q[7:4], pb_q != sh_q[3:0], pg_q != sh_q[15:8]};
  assign cell_hit  = rd_vld_q && (cell_mask != 3'd0);

  logic [ADDR_W-1:0] sw_addr;
  assign sw_addr = cmd_i.clr_step ? idx_q[ADDR_W-1:0] : rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step || cell_hit) shown_mem[sw_addr] <= cmd_i.clr_step ? 16'd0 : {pg_q, pf_q, pb_q};
    if (cmd_i.row_issue) sh_q <= shown_mem[rd_addr];
  end

  // sound registers
  logic [1:0] snd_mask;
  logic       snd_hit;
  assign snd_mask = {pvol_q[ch_s] != svol_q[ch_s], pnote_q[ch_s] != snote_q[ch_s]};
  assign snd_hit  = cmd_i.snd_step && (snd_mask != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        pnote_q[i] <= '0;
        pvol_q[i]  <= '0;
        snote_q[i] <= '0;
        svol_q[i]  <= '0;
      end
    end else begin
      if (snd_wr) begin
        pvol_q[ch_w] <= (note_i == 8'd0) ? 8'd0 : volume_i;
        if (note_i != 8'd0) pnote_q[ch_w] <= note_i;
      end
      if (cmd_i.snd_step) begin
        pvol_q[ch_s] <= 8'd0;
        if (snd_hit) begin
          snote_q[ch_s] <= pnote_q[ch_s];
          svol_q[ch_s]  <= pvol_q[ch_s];
        end
      end
    end
  end

  // one result is held back so the last one can be flagged
  res_t proc;
  logic proc_vld;
  always_comb begin
    proc = '0;
    if (rd_vld_q) begin
      proc.kind  = KIND_CELL;
      proc.place = 5'(rd_col_q);
      proc.line  = 4'(row_q);
      proc.code  = pg_q;
      proc.level = 8'(pf_q);
      proc.back  = pb_q;
      proc.mask  = cell_mask;
    end else begin
      proc.kind  = KIND_SOUND;
      proc.place = 5'(ch_s);
      proc.code  = pnote_q[ch_s];
      proc.level = pvol_q[ch_s];
      proc.mask  = {1'b0, snd_mask};
    end
  end
  assign proc_vld = cell_hit || snd_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= hold_vld_q && (proc_vld || cmd_i.flush_hold);
      if (proc_vld) begin
        hold_vld_q <= 1'b1;
      end else if (cmd_i.flush_hold) begin
        hold_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_vld) hold_q <= proc;
    if (proc_vld || cmd_i.flush_hold) begin
      res_q  <= hold_q;
      last_q <= cmd_i.flush_hold;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign last_o  = last_q;

endmodule

/* design/text_cell_buffer_diff_flush.sv */
// Top level of the double-buffered text cell and sound register block.
// Depends on tcbdf_pkg, tcbdf_ctrl and tcbdf_dp.
//
// Commands enter on start_i while busy_o is low. A cell write or sound write
// gives no result. A row flush walks the row one column per cycle through the
// cell memory read port before busy_o drops; a sound flush walks the sound
// channels. A flush of a row outside the grid starts no scan and leaves busy_o
// low. Results appear on the result ports for one cycle each, marked by
// valid_o. Each change is held until the next change turns up or the scan
// ends, so a transfer lags behind its column (or channel); the final transfer
// of a flush, flagged by last_o, comes in the same cycle that busy_o drops.
// The receiver cannot stall: every strobed transfer must be taken. After
// reset the block clears its cell stores, one address per cycle, and stays
// busy until every address is cleared.
module text_cell_buffer_diff_flush import tcbdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] operation_i,
  input  logic [6:0] column_i,
  input  logic [5:0] row_i,
  input  logic [7:0] glyph_i,
  input  logic [5:0] fore_color_i,
  input  logic [5:0] back_color_i,
  input  logic [1:0] channel_i,
  input  logic [7:0] note_i,
  input  logic [7:0] volume_i,
  output logic       valid_o,
  output logic       kind_o,
  output logic [4:0] place_o,
  output logic [3:0] line_o,
  output logic [7:0] code_o,
  output logic [7:0] fore_or_level_o,
  output logic [3:0] back_out_o,
  output logic [2:0] change_mask_o,
  output logic       last_o
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  // sequencing: clear pass, scans, final transfer release
  tcbdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  // stores, compare logic and result registers
  tcbdf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .operation_i  (operation_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .glyph_i      (glyph_i),
    .fore_color_i (fore_color_i),
    .back_color_i (back_color_i),
    .channel_i    (channel_i),
    .note_i       (note_i),
    .volume_i     (volume_i),
    .valid_o      (valid_o),
    .res_o        (res),
    .last_o       (last_o)
  );

  assign kind_o          = res.kind;
  assign place_o         = res.place;
  assign line_o          = res.line;
  assign code_o          = res.code;
  assign fore_or_level_o = res.level;
  assign back_out_o      = res.back;
  assign change_mask_o   = res.mask;

endmodule
